// File: sv/dspt_pkg.sv
`default_nettype none
package dspt_pkg;

   localparam logic [2:0] OP_LOAD   = 3'd0;
   localparam logic [2:0] OP_BUILD  = 3'd1;
   localparam logic [2:0] OP_DELETE = 3'd2;
   localparam logic [2:0] OP_INSERT = 3'd3;
   localparam logic [2:0] OP_UPDATE = 3'd4;
   localparam logic [2:0] OP_READ   = 3'd5;

   localparam logic [1:0] STAT_DONE  = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_RANGE = 2'd2;

   localparam logic CSR_VERTEX_COUNT = 1'b0;
   localparam logic CSR_DEPTH_LIMIT  = 1'b1;

   localparam logic [31:0] DIST_INF = 32'hFFFF_FFFF;

   typedef enum logic [5:0] {
      S_INIT_CLR, S_IDLE, S_DECODE, S_DONE, S_LOAD,
      S_B_CLR, S_B_SRC, S_B_SEL_INIT, S_B_SEL_RD, S_B_SEL_CK, S_B_SET_RD, S_B_SET_WR,
      S_B_E_RD, S_B_E_WT, S_B_E_CK,
      S_D_RD, S_D_CK, S_D_FIN, S_D_V, S_D_U,
      S_I_WR, S_I_RA, S_I_RB,
      S_R_RD, S_R_Q,
      S_U_VRD, S_U_VCK, S_U_POP, S_U_X, S_U_C_RD, S_U_C_CK, S_U_DC_RD, S_U_DC_WR,
      S_U_PASS, S_U_CP_RD, S_U_CP_WR, S_U_RV_RD, S_U_RV_CK,
      S_U_E_RD, S_U_E_WT, S_U_C1, S_U_C2
   } ctl_state_type;

   typedef struct packed {
      ctl_state_type step;
      logic          accept;
   } ctl_cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       reject;
      logic       clr_last;
      logic       vend;
      logic       cend;
      logic       eend;
      logic       found;
      logic       nbr_ok;
      logic       par_hit;
      logic       del_mark;
      logic       snap_mark;
      logic       qdone;
      logic       change;
      logic       rsp_free;
   } dsp_sts_type;

   // saturating add, all ones stands for unreachable
   function automatic logic [31:0] sat_add(input logic [31:0] d, input logic [15:0] w);
      logic [32:0] s;
      s = {1'b0, d} + {17'b0, w};
      return (s >= {1'b0, DIST_INF}) ? DIST_INF : s[31:0];
   endfunction

endpackage
`default_nettype wire

// File: sv/dynamic_shortest_path_tree.sv
`default_nettype none
// Channel  Ports                                  Contents
// req      req_tvalid/tready/tdata[39:0]/tuser    one operation beat
// rsp      rsp_tvalid/tready/tdata[47:0]/tuser    one result beat per operation
// csr      csr_valid/ready/index/data             vertex_count, depth_limit
//
// Build first clears all MAX_VERTICES records, then, per settled vertex, runs a minimum
// search over the n vertices and a pass over its edges; delete compacts the edge list in
// one pass, and update checks the vertices and tree children, then relaxes edges in passes.
// Everything is paced by the single read and write port of the vertex memory.
// After reset a clearing pass over all MAX_VERTICES vertex records runs before req_tready rises.
// A waiting rsp beat holds the next result but not the acceptance of a new req beat.
module dynamic_shortest_path_tree #(
   parameter int MAX_VERTICES = 1024,
   parameter int MAX_EDGES    = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // vertex_a, vertex_b, weight, zero pad
   input  wire logic [2:0]  req_tuser,  // operation
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,  // distance, reachable, parent_vertex, has_parent, pad
   output logic [1:0]       rsp_tuser,  // status
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [10:0] csr_data
);
   import dspt_pkg::*;

   ctl_cmd_type cmd;
   dsp_sts_type sts;

   dspt_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .cmd(cmd), .sts(sts));

   dspt_dpath #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_dpath (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser));
endmodule
`default_nettype wire

// File: sv/dspt_ram.sv
`default_nettype none
module dspt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                                rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_q_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_q_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_q_ff;
endmodule
`default_nettype wire

// File: sv/dspt_ctrl.sv
`default_nettype none
module dspt_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   output dspt_pkg::ctl_cmd_type     cmd,
   input  wire dspt_pkg::dsp_sts_type sts
);
   import dspt_pkg::*;

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_INIT_CLR:   if (sts.clr_last) state_in = S_IDLE;
         S_IDLE:       if (req_tvalid) state_in = S_DECODE;
         S_DECODE: begin
            if (sts.reject) begin
               state_in = S_DONE;
            end else begin
               unique case (sts.op)
                  OP_LOAD:   state_in = S_LOAD;
                  OP_BUILD:  state_in = S_B_CLR;
                  OP_DELETE: state_in = S_D_RD;
                  OP_INSERT: state_in = S_I_WR;
                  OP_UPDATE: state_in = S_U_VRD;
                  OP_READ:   state_in = S_R_RD;
                  default:   state_in = S_DONE;
               endcase
            end
         end
         S_DONE:       if (sts.rsp_free) state_in = S_IDLE;
         S_LOAD:       state_in = S_DONE;
         S_B_CLR:      if (sts.clr_last) state_in = S_B_SRC;
         S_B_SRC:      state_in = S_B_SEL_INIT;
         S_B_SEL_INIT: state_in = S_B_SEL_RD;
         S_B_SEL_RD: begin
            if (sts.vend) state_in = sts.found ? S_B_SET_RD : S_DONE;
            else          state_in = S_B_SEL_CK;
         end
         S_B_SEL_CK:   state_in = S_B_SEL_RD;
         S_B_SET_RD:   state_in = S_B_SET_WR;
         S_B_SET_WR:   state_in = S_B_E_RD;
         S_B_E_RD:     state_in = sts.eend ? S_B_SEL_INIT : S_B_E_WT;
         S_B_E_WT:     state_in = sts.nbr_ok ? S_B_E_CK : S_B_E_RD;
         S_B_E_CK:     state_in = S_B_E_RD;
         S_D_RD:       state_in = sts.eend ? S_D_FIN : S_D_CK;
         S_D_CK:       state_in = S_D_RD;
         S_D_FIN:      state_in = S_D_V;
         S_D_V:        state_in = sts.par_hit ? S_DONE : S_D_U;
         S_D_U:        state_in = S_DONE;
         S_I_WR:       state_in = S_I_RA;
         S_I_RA:       state_in = S_I_RB;
         S_I_RB:       state_in = S_DONE;
         S_R_RD:       state_in = S_R_Q;
         S_R_Q:        state_in = S_DONE;
         S_U_VRD:      state_in = sts.vend ? S_U_PASS : S_U_VCK;
         S_U_VCK:      state_in = sts.del_mark ? S_U_POP : S_U_VRD;
         S_U_POP:      state_in = sts.qdone ? S_U_DC_RD : S_U_X;
         S_U_X:        state_in = S_U_C_RD;
         S_U_C_RD:     state_in = sts.cend ? S_U_POP : S_U_C_CK;
         S_U_C_CK:     state_in = S_U_C_RD;
         S_U_DC_RD:    state_in = S_U_DC_WR;
         S_U_DC_WR:    state_in = S_U_VRD;
         S_U_PASS:     state_in = S_U_CP_RD;
         S_U_CP_RD:    state_in = sts.vend ? S_U_RV_RD : S_U_CP_WR;
         S_U_CP_WR:    state_in = S_U_CP_RD;
         S_U_RV_RD: begin
            if (sts.vend) state_in = sts.change ? S_U_PASS : S_DONE;
            else          state_in = S_U_RV_CK;
         end
         S_U_RV_CK:    state_in = sts.snap_mark ? S_U_E_RD : S_U_RV_RD;
         S_U_E_RD:     state_in = sts.eend ? S_U_RV_RD : S_U_E_WT;
         S_U_E_WT:     state_in = sts.nbr_ok ? S_U_C1 : S_U_E_RD;
         S_U_C1:       state_in = S_U_C2;
         S_U_C2:       state_in = S_U_E_RD;
         default:      state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == S_IDLE);
      cmd.step   = state_ff;
      cmd.accept = (state_ff == S_IDLE) && req_tvalid;
   end
endmodule
`default_nettype wire

// File: sv/dspt_dpath.sv
`default_nettype none
module dspt_dpath #(
   parameter int MAX_VERTICES = 1024,
   parameter int MAX_EDGES    = 4096
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dspt_pkg::ctl_cmd_type cmd,
   output dspt_pkg::dsp_sts_type      sts,
   input  wire logic [39:0]           req_tdata,
   input  wire logic [2:0]            req_tuser,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic                  csr_index,
   input  wire logic [10:0]           csr_data,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [47:0]                rsp_tdata,
   output logic [1:0]                 rsp_tuser
);
   import dspt_pkg::*;

   localparam int VW  = $clog2(MAX_VERTICES);
   localparam int NW  = $clog2(MAX_VERTICES + 1);
   localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ECW = $clog2(MAX_EDGES + 1);
   localparam int ERW = 2 * VW + 16;

   typedef struct packed {
      logic [31:0]   path_len;
      logic          par_ok;
      logic [VW-1:0] par;
      logic          aff;
      logic          del;
      logic          set;
      logic          snap;
   } vrec_type;

   localparam int VRW = $bits(vrec_type);
   localparam vrec_type CLR_REC = '{path_len: DIST_INF, par_ok: 1'b0, par: '0,
                                    aff: 1'b0, del: 1'b0, set: 1'b0, snap: 1'b0};

   // configuration
   logic [10:0] vc_ff;
   logic [9:0]  depth_ff;
   logic [NW-1:0] n;

   // latched item
   logic [2:0]  op_ff, op_in;
   logic [9:0]  a_ff, a_in, b_ff, b_in;
   logic [15:0] w_ff, w_in;

   // control registers
   logic [ECW-1:0] ecnt_ff, ecnt_in, ei_ff, ei_in, k_ff, k_in;
   logic [NW-1:0]  vi_ff, vi_in, ci_ff, ci_in, cnt_ff, cnt_in;
   logic [VW-1:0]  head_ff, head_in;
   logic [10:0]    lvl_ff, lvl_in;
   logic           found_ff, found_in, change_ff, change_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [VW-1:0]  u_ff, u_in, x_ff, x_in, m_ff, m_in;
   logic [31:0]    best_ff, best_in;
   logic [15:0]    ew_ff, ew_in;
   vrec_type       rec0_ff, rec0_in, rec1_ff, rec1_in;
   logic [31:0]    res_dist_ff, res_dist_in;
   logic           res_reach_ff, res_reach_in, res_hp_ff, res_hp_in;
   logic [9:0]     res_par_ff, res_par_in;
   logic [1:0]     res_st_ff, res_st_in;
   logic [43:0]    rsp_data_ff, rsp_data_in;
   logic [1:0]     rsp_user_ff, rsp_user_in;

   // memories
   logic           vr_we;
   logic [VW-1:0]  vr_wa, vr_ra;
   vrec_type       vr_wd, vr_q;
   logic           er_we;
   logic [EAW-1:0] er_wa, er_ra;
   logic [ERW-1:0] er_wd, er_q;
   logic           q_we;
   logic [VW-1:0]  q_wa, q_ra, q_wd, q_q;

   dspt_ram #(.WIDTH(VRW), .DEPTH(MAX_VERTICES)) u_vram (
      .clock(clock), .wr_en(vr_we), .wr_addr(vr_wa), .wr_data(vr_wd),
      .rd_addr(vr_ra), .rd_data(vr_q));

   dspt_ram #(.WIDTH(ERW), .DEPTH(MAX_EDGES)) u_eram (
      .clock(clock), .wr_en(er_we), .wr_addr(er_wa), .wr_data(er_wd),
      .rd_addr(er_ra), .rd_data(er_q));

   dspt_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_qram (
      .clock(clock), .wr_en(q_we), .wr_addr(q_wa), .wr_data(q_wd),
      .rd_addr(q_ra), .rd_data(q_q));

   // derived values
   logic [VW-1:0] av, bv, ea, eb, nbr_v, nbr_other;
   logic [15:0]   ew;
   logic          a_ok, b_ok, full, nbr_ok, same, push_ok, qdone, reject, x_is_a;
   logic [1:0]    rej_code;
   logic [NW:0]   push_sum, push_mod;
   logic [VW-1:0] head_nx;
   logic [31:0]   sat_b, sat_c1, sat_c2, ins_nd, ins_yd;

   always_comb begin
      if (vc_ff == 11'd0) begin
         n = NW'(1);
      end else if (32'(vc_ff) > 32'(MAX_VERTICES)) begin
         n = NW'(MAX_VERTICES);
      end else begin
         n = NW'(vc_ff);
      end
   end

   assign av   = VW'(a_ff);
   assign bv   = VW'(b_ff);
   assign a_ok = 32'(a_ff) < 32'(n);
   assign b_ok = 32'(b_ff) < 32'(n);
   assign full = (ecnt_ff == ECW'(MAX_EDGES));

   assign ea = er_q[VW-1:0];
   assign eb = er_q[2*VW-1:VW];
   assign ew = er_q[ERW-1:2*VW];

   assign nbr_v     = (cmd.step == S_B_E_WT) ? u_ff : vi_ff[VW-1:0];
   assign nbr_ok    = (NW'(ea) < n) && (NW'(eb) < n) && ((ea == nbr_v) || (eb == nbr_v));
   assign nbr_other = (ea == nbr_v) ? eb : ea;
   assign same      = (ew == w_ff) && (((ea == av) && (eb == bv)) || ((ea == bv) && (eb == av)));

   assign head_nx  = (head_ff == VW'(MAX_VERTICES - 1)) ? '0 : head_ff + VW'(1);
   assign push_sum = (NW + 1)'(head_ff) + (NW + 1)'(cnt_ff);
   assign push_mod = (push_sum >= (NW + 1)'(MAX_VERTICES)) ?
                     push_sum - (NW + 1)'(MAX_VERTICES) : push_sum;
   assign push_ok  = (lvl_ff < {1'b0, depth_ff}) && (cnt_ff < NW'(MAX_VERTICES));
   assign qdone    = (cnt_ff == '0) || (lvl_ff > {1'b0, depth_ff});

   assign sat_b  = sat_add(best_ff, ew_ff);
   assign sat_c1 = sat_add(vr_q.path_len, ew_ff);
   assign sat_c2 = sat_add(rec0_ff.path_len, ew_ff);
   assign x_is_a = rec0_ff.path_len < vr_q.path_len;
   assign ins_nd = sat_add(x_is_a ? rec0_ff.path_len : vr_q.path_len, w_ff);
   assign ins_yd = x_is_a ? vr_q.path_len : rec0_ff.path_len;

   always_comb begin
      rej_code = STAT_DONE;
      priority if (op_ff == OP_LOAD || op_ff == OP_DELETE || op_ff == OP_INSERT) begin
         if (!a_ok || !b_ok) rej_code = STAT_RANGE;
         else if (op_ff != OP_DELETE && full) rej_code = STAT_FULL;
      end else if (op_ff == OP_BUILD || op_ff == OP_READ) begin
         if (!a_ok) rej_code = STAT_RANGE;
      end
      reject = (rej_code != STAT_DONE);
   end

   always_comb begin
      sts.op        = op_ff;
      sts.reject    = reject;
      sts.clr_last  = (vi_ff == NW'(MAX_VERTICES - 1));
      sts.vend      = (vi_ff == n);
      sts.cend      = (ci_ff == n);
      sts.eend      = (ei_ff == ecnt_ff);
      sts.found     = found_ff;
      sts.nbr_ok    = nbr_ok;
      sts.par_hit   = vr_q.par_ok && (vr_q.par == ((cmd.step == S_D_V) ? av : bv));
      sts.del_mark  = vr_q.del;
      sts.snap_mark = vr_q.snap;
      sts.qdone     = qdone;
      sts.change    = change_ff;
      sts.rsp_free  = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      vrec_type r;
      r = vr_q;

      op_in = op_ff; a_in = a_ff; b_in = b_ff; w_in = w_ff;
      ecnt_in = ecnt_ff; ei_in = ei_ff; k_in = k_ff;
      vi_in = vi_ff; ci_in = ci_ff; cnt_in = cnt_ff; head_in = head_ff; lvl_in = lvl_ff;
      found_in = found_ff; change_in = change_ff;
      u_in = u_ff; x_in = x_ff; m_in = m_ff; best_in = best_ff; ew_in = ew_ff;
      rec0_in = rec0_ff; rec1_in = rec1_ff;
      res_dist_in = res_dist_ff; res_reach_in = res_reach_ff; res_hp_in = res_hp_ff;
      res_par_in = res_par_ff; res_st_in = res_st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff; rsp_user_in = rsp_user_ff;

      vr_we = 1'b0; vr_wa = '0; vr_wd = CLR_REC; vr_ra = '0;
      er_we = 1'b0; er_wa = '0; er_wd = '0; er_ra = '0;
      q_we = 1'b0; q_wa = '0; q_wd = '0; q_ra = '0;

      unique case (cmd.step)
         S_INIT_CLR, S_B_CLR: begin
            vr_we = 1'b1;
            vr_wa = vi_ff[VW-1:0];
            vi_in = (vi_ff == NW'(MAX_VERTICES - 1)) ? '0 : vi_ff + NW'(1);
         end
         S_IDLE: begin
            if (cmd.accept) begin
               op_in = req_tuser;
               a_in  = req_tdata[9:0];
               b_in  = req_tdata[19:10];
               w_in  = req_tdata[35:20];
            end
         end
         S_DECODE: begin
            vi_in = '0; ei_in = '0; k_in = '0;
            res_dist_in = '0; res_reach_in = 1'b0; res_hp_in = 1'b0; res_par_in = '0;
            res_st_in = rej_code;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {res_hp_ff, res_par_ff, res_reach_ff, res_dist_ff};
               rsp_user_in  = res_st_ff;
            end
         end
         S_LOAD: begin
            er_we = 1'b1; er_wa = ecnt_ff[EAW-1:0]; er_wd = {w_ff, bv, av};
            ecnt_in = ecnt_ff + ECW'(1);
         end
         S_B_SRC: begin
            r = CLR_REC; r.path_len = '0; r.par_ok = 1'b1; r.par = av;
            vr_we = 1'b1; vr_wa = av; vr_wd = r;
         end
         S_B_SEL_INIT: begin
            vi_in = '0; found_in = 1'b0; best_in = DIST_INF;
         end
         S_B_SEL_RD: vr_ra = vi_ff[VW-1:0];
         S_B_SEL_CK: begin
            if (!vr_q.set && vr_q.path_len < best_ff) begin
               best_in = vr_q.path_len; u_in = vi_ff[VW-1:0]; found_in = 1'b1;
            end
            vi_in = vi_ff + NW'(1);
         end
         S_B_SET_RD: vr_ra = u_ff;
         S_B_SET_WR: begin
            r.set = 1'b1;
            vr_we = 1'b1; vr_wa = u_ff; vr_wd = r;
            ei_in = '0;
         end
         S_B_E_RD, S_D_RD, S_U_E_RD: begin
            er_ra = ei_ff[EAW-1:0];
            if (cmd.step == S_U_E_RD && ei_ff == ecnt_ff) vi_in = vi_ff + NW'(1);
         end
         S_B_E_WT, S_U_E_WT: begin
            if (nbr_ok) begin
               vr_ra = nbr_other; m_in = nbr_other; ew_in = ew;
            end else begin
               ei_in = ei_ff + ECW'(1);
            end
         end
         S_B_E_CK: begin
            if (vr_q.path_len > sat_b) begin
               r.path_len = sat_b; r.par_ok = 1'b1; r.par = u_ff;
               vr_we = 1'b1; vr_wa = m_ff; vr_wd = r;
            end
            ei_in = ei_ff + ECW'(1);
         end
         S_D_CK: begin
            if (!same) begin
               er_we = 1'b1; er_wa = k_ff[EAW-1:0]; er_wd = er_q;
               k_in = k_ff + ECW'(1);
            end
            ei_in = ei_ff + ECW'(1);
         end
         S_D_FIN: begin
            ecnt_in = k_ff;
            vr_ra = bv;
         end
         S_D_V, S_D_U: begin
            if (sts.par_hit) begin
               r.path_len = DIST_INF; r.par_ok = 1'b0; r.par = '0; r.aff = 1'b1;
               r.del = 1'b1;
               vr_we = 1'b1; vr_wa = (cmd.step == S_D_V) ? bv : av; vr_wd = r;
            end else begin
               vr_ra = av;
            end
         end
         S_I_WR: begin
            er_we = 1'b1; er_wa = ecnt_ff[EAW-1:0]; er_wd = {w_ff, bv, av};
            ecnt_in = ecnt_ff + ECW'(1);
            vr_ra = av;
         end
         S_I_RA: begin
            rec0_in = vr_q;
            vr_ra = bv;
         end
         S_I_RB: begin
            // the nearer endpoint relaxes the farther one
            if (ins_nd < ins_yd) begin
               r = x_is_a ? vr_q : rec0_ff;
               r.path_len = ins_nd; r.par_ok = 1'b1; r.par = x_is_a ? av : bv; r.aff = 1'b1;
               vr_we = 1'b1; vr_wa = x_is_a ? bv : av; vr_wd = r;
            end
         end
         S_R_RD: vr_ra = av;
         S_R_Q: begin
            res_dist_in  = vr_q.path_len;
            res_reach_in = (vr_q.path_len != DIST_INF);
            res_hp_in    = vr_q.par_ok;
            res_par_in   = vr_q.par_ok ? 10'(vr_q.par) : '0;
         end
         S_U_VRD, S_U_DC_RD, S_U_CP_RD, S_U_RV_RD: begin
            vr_ra = vi_ff[VW-1:0];
            if (cmd.step == S_U_CP_RD && vi_ff == n) vi_in = '0;
         end
         S_U_VCK: begin
            if (vr_q.del) begin
               q_we = 1'b1; q_wa = '0; q_wd = vi_ff[VW-1:0];
               head_in = '0; cnt_in = NW'(1); lvl_in = '0;
            end else begin
               vi_in = vi_ff + NW'(1);
            end
         end
         S_U_POP: begin
            if (!qdone) begin
               q_ra = head_ff; head_in = head_nx; cnt_in = cnt_ff - NW'(1);
            end
         end
         S_U_X: begin
            x_in = q_q; ci_in = '0;
         end
         S_U_C_RD: begin
            if (ci_ff == n) lvl_in = lvl_ff + 11'd1;
            else            vr_ra = ci_ff[VW-1:0];
         end
         S_U_C_CK: begin
            if (vr_q.par_ok && vr_q.par == x_ff) begin
               r.path_len = DIST_INF; r.par_ok = 1'b0; r.par = '0; r.aff = 1'b1;
               r.del = 1'b1;
               vr_we = 1'b1; vr_wa = ci_ff[VW-1:0]; vr_wd = r;
               if (push_ok) begin
                  q_we = 1'b1; q_wa = push_mod[VW-1:0]; q_wd = ci_ff[VW-1:0];
                  cnt_in = cnt_ff + NW'(1);
               end
            end
            ci_in = ci_ff + NW'(1);
         end
         S_U_DC_WR: begin
            r.del = 1'b0;
            vr_we = 1'b1; vr_wa = vi_ff[VW-1:0]; vr_wd = r;
            vi_in = vi_ff + NW'(1);
         end
         S_U_PASS: begin
            vi_in = '0; change_in = 1'b0;
         end
         S_U_CP_WR: begin
            r.snap = vr_q.aff;
            vr_we = 1'b1; vr_wa = vi_ff[VW-1:0]; vr_wd = r;
            vi_in = vi_ff + NW'(1);
         end
         S_U_RV_CK: begin
            if (vr_q.snap) begin
               r.aff = 1'b0;
               rec0_in = r;
               vr_we = 1'b1; vr_wa = vi_ff[VW-1:0]; vr_wd = r;
               ei_in = '0;
            end else begin
               vi_in = vi_ff + NW'(1);
            end
         end
         S_U_C1: begin
            // pull v through the neighbor
            rec1_in = vr_q;
            if (rec0_ff.path_len > sat_c1) begin
               r = rec0_ff;
               r.path_len = sat_c1; r.par_ok = 1'b1; r.par = m_ff; r.aff = 1'b1;
               rec0_in = r;
               vr_we = 1'b1; vr_wa = vi_ff[VW-1:0]; vr_wd = r;
               change_in = 1'b1;
            end
         end
         S_U_C2: begin
            // push from v into the neighbor
            if (rec1_ff.path_len > sat_c2) begin
               r = rec1_ff;
               r.path_len = sat_c2; r.par_ok = 1'b1; r.par = vi_ff[VW-1:0]; r.aff = 1'b1;
               vr_we = 1'b1; vr_wa = m_ff; vr_wd = r;
               change_in = 1'b1;
            end
            ei_in = ei_ff + ECW'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff        <= 11'd1024;
         depth_ff     <= 10'd50;
         ecnt_ff      <= '0;
         ei_ff        <= '0;
         k_ff         <= '0;
         vi_ff        <= '0;
         ci_ff        <= '0;
         cnt_ff       <= '0;
         head_ff      <= '0;
         lvl_ff       <= '0;
         found_ff     <= 1'b0;
         change_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_VERTEX_COUNT: vc_ff    <= csr_data;
               CSR_DEPTH_LIMIT:  depth_ff <= csr_data[9:0];
               default: begin
               end
            endcase
         end
         ecnt_ff      <= ecnt_in;
         ei_ff        <= ei_in;
         k_ff         <= k_in;
         vi_ff        <= vi_in;
         ci_ff        <= ci_in;
         cnt_ff       <= cnt_in;
         head_ff      <= head_in;
         lvl_ff       <= lvl_in;
         found_ff     <= found_in;
         change_ff    <= change_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      w_ff         <= w_in;
      u_ff         <= u_in;
      x_ff         <= x_in;
      m_ff         <= m_in;
      best_ff      <= best_in;
      ew_ff        <= ew_in;
      rec0_ff      <= rec0_in;
      rec1_ff      <= rec1_in;
      res_dist_ff  <= res_dist_in;
      res_reach_ff <= res_reach_in;
      res_hp_ff    <= res_hp_in;
      res_par_ff   <= res_par_in;
      res_st_ff    <= res_st_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_data_ff};
   assign rsp_tuser  = rsp_user_ff;
endmodule
`default_nettype wire
